// ----- hdl/audio_imu_impact_detector_top_assert.svh -----
// assertion macros for the impact detector
`ifndef AUDIO_IMU_IMPACT_DETECTOR_TOP_ASSERT_SVH
`define AUDIO_IMU_IMPACT_DETECTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define AIID_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AIID_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AIID_ASSERT(label, clk, rst, prop, msg)
`define AIID_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- hdl/aiid_pkg.sv -----
// ----------------------------------------------------------------------------
// aiid_pkg
// shared constants and types of the audio and motion impact detector
// ----------------------------------------------------------------------------
package aiid_pkg;
   localparam int FRAME_MAX = 512;
   localparam int FCNT_W = $clog2(FRAME_MAX + 1);
   localparam int SUM_W = 40;

   localparam logic [2:0] REG_ACCEL_THR = 3'd0;
   localparam logic [2:0] REG_REL_THR = 3'd1;
   localparam logic [2:0] REG_MIN_PEAK = 3'd2;
   localparam logic [2:0] REG_ALPHA = 3'd3;
   localparam logic [2:0] REG_WINDOW = 3'd4;
   localparam logic [2:0] REG_DEBOUNCE = 3'd5;

   typedef struct packed {
      logic start;
      logic [SUM_W-1:0] dividend;
      logic [FCNT_W-1:0] divisor;
   } root_req_type;

   typedef struct packed {
      logic done;
      logic [15:0] root;
   } root_rsp_type;
endpackage

// ----- hdl/audio_imu_impact_detector_top.sv -----
// an audio item that ends no frame passes through S_AUD, an accel item through S_ACC
// a frame end passes S_AUD, S_ROOT, S_DEC, S_BASE and S_OUT (S_BASE skipped on a spike)
// 40 bit-serial divide steps and 16 root steps make up S_ROOT
// accel magnitude is squared one axis per cycle through a 16x16 multiplier
// a result waiting on rsp_tready holds back only the next frame end at its output
// synchronous active-high reset restores register defaults and clears frame, baseline and event state
// ----------------------------------------------------------------------------
// audio_imu_impact_detector_top
// frame rms, peak and zero-crossing analysis with moving baseline and motion
// confirmation of impacts
// ----------------------------------------------------------------------------
`include "audio_imu_impact_detector_top_assert.svh"
module audio_imu_impact_detector_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [95:0] req_tdata,  // sample, accel_x, accel_y, accel_z, time_ms
   input  logic req_tlast,
   input  logic req_tuser,         // op
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [47:0] rsp_tdata,  // rms, peak, crossings, audio_spike, impact
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   localparam int FW = aiid_pkg::FCNT_W;
   localparam int SW = aiid_pkg::SUM_W;
   typedef enum logic [2:0] {S_IDLE, S_AUD, S_ACC, S_ROOT, S_DEC, S_BASE, S_OUT}
      state_type;

   state_type state_ff;
   logic [31:0] thr_ff;
   logic [15:0] rel_ff, minp_ff, alpha_ff, win_ff, deb_ff;
   logic [SW-1:0] sum_ff;
   logic [15:0] peak_ff;
   logic [8:0] cross_ff;
   logic [FW-1:0] fcnt_ff;
   logic prev_neg_ff;
   logic [24:0] base_ff;
   logic [31:0] mtime_ff, atime_ff, itime_ff;
   logic [15:0] samp_ff, ax_ff, ay_ff, az_ff;
   logic [31:0] now_ff;
   logic last_ff;
   logic [1:0] axis_ff;
   logic [33:0] mag_ff;
   logic [31:0] prod_ff;
   logic [15:0] rms_ff;
   logic spike_ff;
   logic [47:0] out_ff;
   logic out_v_ff;
   logic [1:0] bstep_ff;
   logic [41:0] acc_ff;

   aiid_pkg::root_req_type rreq;
   aiid_pkg::root_rsp_type rrsp;

   aiid_root u_root (.clock(clock), .reset(reset), .req(rreq), .rsp(rrsp));

   logic [15:0] amag;
   logic [31:0] asq;
   logic [SW:0] sum_add;
   logic [FW-1:0] fcnt_inc;
   logic frame_end;
   logic [15:0] axis_val, axis_abs;
   logic [31:0] aprod;
   logic [15:0] mul_a, mul_b;
   logic [31:0] mul_p;
   logic [31:0] dm, da, di;
   logic rec_m, rec_a, deb_ok;
   logic out_load;

   always_comb begin
      amag = samp_ff[15] ? 16'(-samp_ff) : samp_ff;
      asq = amag * amag;
      sum_add = {1'b0, sum_ff} + {9'd0, asq};
      fcnt_inc = fcnt_ff + 1'b1;
      frame_end = last_ff || ({1'b0, fcnt_inc} >= (FW+1)'(aiid_pkg::FRAME_MAX));
      axis_val = (axis_ff == 2'd0) ? ax_ff : (axis_ff == 2'd1) ? ay_ff : az_ff;
      axis_abs = axis_val[15] ? 16'(-axis_val) : axis_val;
      aprod = axis_abs * axis_abs;
      // shared multiplier for the three baseline products and the low relative-test product
      case (bstep_ff)
         2'd0: begin mul_a = alpha_ff; mul_b = rms_ff; end
         2'd1: begin mul_a = 16'(17'h10000 - {1'b0, alpha_ff}); mul_b = base_ff[15:0]; end
         2'd2: begin mul_a = 16'(17'h10000 - {1'b0, alpha_ff}); mul_b = {7'd0, base_ff[24:16]}; end
         default: begin mul_a = rel_ff; mul_b = base_ff[15:0]; end
      endcase
      mul_p = mul_a * mul_b;
      dm = now_ff - mtime_ff;
      da = now_ff - atime_ff;
      di = now_ff - itime_ff;
      rec_m = (mtime_ff != '0) && (dm < {16'd0, win_ff});
      rec_a = (atime_ff != '0) && (da < {16'd0, win_ff});
      deb_ok = di > {16'd0, deb_ff};
      rreq.start = (state_ff == S_AUD) && frame_end;
      rreq.dividend = (sum_add[SW]) ? {SW{1'b1}} : sum_add[SW-1:0];
      rreq.divisor = fcnt_inc;
      out_load = (state_ff == S_OUT) && (!out_v_ff || rsp_tready);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;

   // relative test: peak<<16 > base*rel, base split into low 16 and high 9 bits
   logic [41:0] rel_hi_ff;
   logic [47:0] rel_rhs;
   logic rel_ok, abs_ok;
   always_comb begin
      rel_rhs = {6'd0, rel_hi_ff} + {16'd0, prod_ff};
      rel_ok = {peak_ff, 16'd0} > rel_rhs;
      abs_ok = peak_ff > minp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff <= 32'd150994944;
         rel_ff <= 16'd768;
         minp_ff <= 16'd8000;
         alpha_ff <= 16'd6554;
         win_ff <= 16'd200;
         deb_ff <= 16'd1000;
         sum_ff <= '0;
         peak_ff <= '0;
         cross_ff <= '0;
         fcnt_ff <= '0;
         prev_neg_ff <= 1'b0;
         base_ff <= '0;
         mtime_ff <= '0;
         atime_ff <= '0;
         itime_ff <= '0;
         out_v_ff <= 1'b0;
         bstep_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               aiid_pkg::REG_ACCEL_THR: thr_ff <= csr_data;
               aiid_pkg::REG_REL_THR: rel_ff <= csr_data[15:0];
               aiid_pkg::REG_MIN_PEAK: minp_ff <= csr_data[15:0];
               aiid_pkg::REG_ALPHA: alpha_ff <= csr_data[15:0];
               aiid_pkg::REG_WINDOW: win_ff <= csr_data[15:0];
               aiid_pkg::REG_DEBOUNCE: deb_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         if (out_load) out_v_ff <= 1'b1;
         else if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  samp_ff <= req_tdata[15:0];
                  ax_ff <= req_tdata[31:16];
                  ay_ff <= req_tdata[47:32];
                  az_ff <= req_tdata[63:48];
                  now_ff <= req_tdata[95:64];
                  last_ff <= req_tlast;
                  axis_ff <= '0;
                  mag_ff <= '0;
                  state_ff <= req_tuser ? S_ACC : S_AUD;
               end
            end
            S_ACC: begin
               if (axis_ff == 2'd2) begin
                  if (mag_ff + {2'd0, aprod} > {2'd0, thr_ff}) mtime_ff <= now_ff;
                  state_ff <= S_IDLE;
               end else begin
                  mag_ff <= mag_ff + {2'd0, aprod};
               end
               axis_ff <= axis_ff + 2'd1;
            end
            S_AUD: begin
               if (amag > peak_ff) peak_ff <= amag;
               if (fcnt_ff != '0 && (prev_neg_ff != samp_ff[15]) && cross_ff != 9'h1FF)
                  cross_ff <= cross_ff + 9'd1;
               if (frame_end) begin
                  state_ff <= S_ROOT;
               end else begin
                  sum_ff <= sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
                  prev_neg_ff <= samp_ff[15];
                  fcnt_ff <= fcnt_inc;
                  state_ff <= S_IDLE;
               end
               bstep_ff <= 2'd3;
            end
            S_ROOT: begin
               // relative test products computed here while the root runs
               if (bstep_ff == 2'd3) begin
                  prod_ff <= mul_p;
                  bstep_ff <= 2'd2;
               end else if (bstep_ff == 2'd2) begin
                  rel_hi_ff <= 42'(rel_ff * base_ff[24:16]) << 16;
               end
               if (rrsp.done) begin
                  rms_ff <= rrsp.root;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               spike_ff <= rel_ok && abs_ok;
               bstep_ff <= 2'd0;
               acc_ff <= 42'd32768;
               state_ff <= (rel_ok && abs_ok) ? S_OUT : S_BASE;
               if (rel_ok && abs_ok) atime_ff <= now_ff;
            end
            S_BASE: begin
               case (bstep_ff)
                  2'd0: acc_ff <= acc_ff + (42'(mul_p) << 8);
                  2'd1: acc_ff <= acc_ff + 42'(mul_p);
                  default: acc_ff <= acc_ff + (42'(mul_p) << 16)
                     + ((alpha_ff == '0) ? (42'(base_ff) << 16) : 42'd0);
               endcase
               if (bstep_ff == 2'd2) state_ff <= S_OUT;
               bstep_ff <= bstep_ff + 2'd1;
            end
            S_OUT: begin
               if (out_load) begin
                  if (!spike_ff) base_ff <= acc_ff[40:16];
                  out_ff <= {5'd0, (rec_m && rec_a && deb_ok), spike_ff, cross_ff,
                             peak_ff, rms_ff};
                  if (rec_m && rec_a && deb_ok) begin
                     itime_ff <= now_ff;
                     mtime_ff <= '0;
                     atime_ff <= '0;
                  end
                  sum_ff <= '0;
                  peak_ff <= '0;
                  cross_ff <= '0;
                  fcnt_ff <= '0;
                  prev_neg_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `AIID_ASSERT(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> !req_tready, "busy accept")
   `AIID_ASSERT(a_out_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "result dropped")
   `AIID_ASSERT(a_root_in_root, clock, reset, rrsp.done |-> (state_ff == S_ROOT), "stray root")
endmodule

// ----- hdl/aiid_root.sv -----
// ----------------------------------------------------------------------------
// aiid_root
// bit-serial divide of the frame energy by sample count, then bit-serial
// integer square root of the saturated mean
// ----------------------------------------------------------------------------
module aiid_root (
   input  logic clock,
   input  logic reset,
   input  aiid_pkg::root_req_type req,
   output aiid_pkg::root_rsp_type rsp
);
   typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROOT} state_type;
   localparam int SW = aiid_pkg::SUM_W;
   localparam int FW = aiid_pkg::FCNT_W;

   state_type state_ff;
   logic [5:0] cnt_ff;
   logic [SW-1:0] num_ff;          // shifts out dividend, shifts in quotient
   logic [FW-1:0] rem_ff;
   logic [FW-1:0] den_ff;
   logic [31:0] x_ff;              // radicand digits
   logic [15:0] r_ff;              // partial remainder
   logic [15:0] q_ff;
   logic done_ff;

   logic [FW:0] rem_sh;
   logic [FW:0] rem_sub;
   logic [17:0] r_sh;
   logic [17:0] trial;

   always_comb begin
      rem_sh = {rem_ff, num_ff[SW-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      r_sh = {r_ff, x_ff[31:30]};
      trial = {q_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  num_ff <= req.dividend;
                  den_ff <= req.divisor;
                  rem_ff <= '0;
                  cnt_ff <= 6'(SW - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (rem_sub[FW] == 1'b0) begin
                  rem_ff <= rem_sub[FW-1:0];
                  num_ff <= {num_ff[SW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[FW-1:0];
                  num_ff <= {num_ff[SW-2:0], 1'b0};
               end
               if (cnt_ff == '0) begin
                  state_ff <= S_ROOT;
                  cnt_ff <= 6'd15;
               end else begin
                  cnt_ff <= cnt_ff - 6'd1;
               end
            end
            S_ROOT: begin
               if (r_sh >= trial) begin
                  r_ff <= 16'(r_sh - trial);
                  q_ff <= {q_ff[14:0], 1'b1};
               end else begin
                  r_ff <= r_sh[15:0];
                  q_ff <= {q_ff[14:0], 1'b0};
               end
               x_ff <= {x_ff[29:0], 2'b00};
               if (cnt_ff == '0) begin
                  state_ff <= S_IDLE;
                  done_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff - 6'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // load the saturated mean as the division finishes
         if (state_ff == S_DIV && cnt_ff == '0) begin
            x_ff <= (num_ff[SW-2:31] != '0) ? 32'hFFFF_FFFF
                    : {num_ff[30:0], ~rem_sub[FW]};
            r_ff <= '0;
            q_ff <= '0;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = q_ff;
endmodule
